// File: src/dbfbp_pkg.sv
package dbfbp_pkg;

  localparam int FrameW  = 32;
  localparam int SizeW   = 40;
  localparam int KindW   = 4;
  localparam int UsageW  = 32;
  localparam int HandleW = 32;
  localparam int BudgetW = 44;
  localparam int DelayW  = 8;
  localparam int CfgW    = 44;

  // Register indexes of the configuration port.
  localparam logic CFG_BUDGET = 1'b0;
  localparam logic CFG_DELAY  = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_STORED  = 2'd0;
  localparam logic [1:0] ST_DROPPED = 2'd1;
  localparam logic [1:0] ST_HIT     = 2'd2;
  localparam logic [1:0] ST_MISS    = 2'd3;

  // One pool entry as it is kept in memory.
  typedef struct packed {
    logic [FrameW-1:0]  frame;
    logic [SizeW-1:0]   size;
    logic [KindW-1:0]   kind;
    logic [UsageW-1:0]  usage;
    logic               mapped;
    logic [HandleW-1:0] handle;
  } entry_t;

endpackage

// File: src/dbfbp_mem.sv
// Entry store: one write port, one read port, registered read data.
module dbfbp_mem
  import dbfbp_pkg::*;
#(
  parameter int Depth = 16,
  parameter int AddrW = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  entry_t           wdata,
  input  logic [AddrW-1:0] raddr,
  output entry_t           rdata
);

  entry_t mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/deferred_best_fit_buffer_pool.sv
// Deferred best-fit buffer pool.
// Input channel (in_valid/in_stall) takes one word per request: a release
// appends a buffer to the ordered pool, a get evicts at most one aged entry
// beyond the byte budget and then reuses the smallest aged exact match.
// Output channel (out_valid/out_stall) returns one word per request.
// The entries live in a single memory with one read and one write port.
// A release result is valid in the cycle after its word is taken.
// A get walks the memory for eviction, closes the gap by moving each
// later entry up one place, walks again for best fit and closes that
// gap the same way. The worst case is an eviction and a hit both at
// the head of the list. One request is in flight at a time; the next
// is taken once its result sits in the output register.
// While the receiver stalls, the result is held and no new request is taken.
// Reset empties the pool and loads the budget with all ones and the reuse
// delay with 2. No clearing pass is needed.
module deferred_best_fit_buffer_pool
  import dbfbp_pkg::*;
#(
  parameter int POOL_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [CfgW-1:0]     cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                req_type,
  input  logic [FrameW-1:0]   frame_now,
  input  logic [SizeW-1:0]    req_size,
  input  logic [KindW-1:0]    mem_kind,
  input  logic [UsageW-1:0]   usage_bits,
  input  logic                mapping,
  input  logic [HandleW-1:0]  handle_in,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          status,
  output logic [HandleW-1:0]  handle_out,
  output logic [SizeW-1:0]    size_out,
  output logic                evicted,
  output logic [HandleW-1:0]  evicted_handle,
  output logic                evicted_mapped
);

  localparam int AddrW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int CntW  = $clog2(POOL_DEPTH + 1);
  localparam int SumW  = SizeW + CntW;
  localparam logic [CntW-1:0] FullCnt = CntW'(POOL_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE, S_EV_SCAN, S_EV_SHIFT, S_FIT_SCAN, S_FIT_SHIFT, S_DONE
  } state_t;

  state_t state;

  logic [BudgetW-1:0] byte_budget;
  logic [DelayW-1:0]  reuse_delay;

  // Captured request.
  logic [FrameW-1:0]  q_now;
  logic [SizeW-1:0]   q_size;
  logic [KindW-1:0]   q_kind;
  logic [UsageW-1:0]  q_usage;
  logic               q_map;

  logic [CntW-1:0]    count;
  logic [CntW-1:0]    rd_idx;   // address issued last cycle
  logic [CntW-1:0]    pos;      // gap position during a shift
  logic               rd_live;  // rdata belongs to rd_idx
  logic [SumW-1:0]    sum;
  logic               found;
  logic [CntW-1:0]    best;
  logic [SizeW-1:0]   best_size;
  logic [HandleW-1:0] best_handle;

  // Memory ports.
  logic              we;
  logic [AddrW-1:0]  waddr, raddr;
  entry_t            wdata, rdata;
  logic [CntW-1:0]   raddr_full;

  dbfbp_mem #(.Depth(POOL_DEPTH), .AddrW(AddrW)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  // Entry tests on the word just read.
  logic [FrameW:0]  aged_lhs;
  logic             aged;
  logic [SumW-1:0]  sum_next;
  logic             over;
  logic             fits;
  logic             accept;

  assign aged_lhs = {1'b0, rdata.frame} + (FrameW+1)'(reuse_delay);
  assign aged     = aged_lhs < {1'b0, q_now};
  assign sum_next = sum + SumW'(rdata.size);
  assign over     = sum_next > SumW'(byte_budget);
  assign fits     = aged && rdata.kind == q_kind && rdata.usage == q_usage
                    && rdata.size >= q_size && (!q_map || rdata.mapped)
                    && (!found || rdata.size < best_size);

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);

  // Read address: scans read rd_idx, or rd_idx+1 once rdata is live; shifts read pos+1.
  always_comb begin
    raddr_full = '0;
    if (state == S_IDLE) raddr_full = '0;
    else if (state == S_EV_SCAN || state == S_FIT_SCAN)
      raddr_full = rd_live ? rd_idx + 1'b1 : rd_idx;
    else raddr_full = pos + 1'b1;
    raddr = raddr_full[AddrW-1:0];
  end

  // Write port: append on release, move up during a shift.
  always_comb begin
    we    = 1'b0;
    waddr = pos[AddrW-1:0];
    wdata = rdata;
    if (state == S_IDLE) begin
      we    = accept && req_type && count < FullCnt;
      waddr = count[AddrW-1:0];
      wdata = '{frame: frame_now, size: req_size, kind: mem_kind,
                usage: usage_bits, mapped: mapping, handle: handle_in};
    end else if ((state == S_EV_SHIFT || state == S_FIT_SHIFT) && rd_live) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      byte_budget <= '1;
      reuse_delay <= DelayW'(2);
      count       <= '0;
      out_valid   <= 1'b0;
      rd_live     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_BUDGET: byte_budget <= cfg_data[BudgetW-1:0];
          CFG_DELAY:  reuse_delay <= cfg_data[DelayW-1:0];
          default: ;
        endcase
      end
      // A taken word clears the output unless a release refills it now.
      if (out_valid && !out_stall && !(accept && req_type)) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            q_now   <= frame_now;
            q_size  <= req_size;
            q_kind  <= mem_kind;
            q_usage <= usage_bits;
            q_map   <= mapping;
            handle_out     <= '0;
            size_out       <= '0;
            evicted        <= 1'b0;
            evicted_handle <= '0;
            evicted_mapped <= 1'b0;
            if (req_type) begin
              out_valid <= 1'b1;
              if (count < FullCnt) begin
                status <= ST_STORED;
                count  <= count + 1'b1;
              end else begin
                status <= ST_DROPPED;
              end
            end else begin
              sum     <= '0;
              rd_idx  <= '0;
              rd_live <= 1'b0;
              state   <= S_EV_SCAN;
            end
          end
        end
        S_EV_SCAN: begin
          if (!rd_live) begin
            if (count == '0) begin
              found <= 1'b0;
              state <= S_FIT_SCAN;
            end else begin
              rd_live <= 1'b1;
            end
          end else begin
            sum <= sum_next;
            if (over && aged) begin
              evicted        <= 1'b1;
              evicted_handle <= rdata.handle;
              evicted_mapped <= rdata.mapped;
              pos     <= rd_idx;
              rd_live <= 1'b0;
              state   <= S_EV_SHIFT;
            end else if (rd_idx + 1'b1 >= count) begin
              rd_idx  <= '0;
              rd_live <= 1'b0;
              found   <= 1'b0;
              state   <= S_FIT_SCAN;
            end else begin
              rd_idx <= rd_idx + 1'b1;
            end
          end
        end
        S_EV_SHIFT, S_FIT_SHIFT: begin
          // pos is the gap; rdata holds entry pos+1 when rd_live.
          if (pos + 1'b1 >= count) begin
            count   <= count - 1'b1;
            rd_live <= 1'b0;
            rd_idx  <= '0;
            found   <= 1'b0;
            if (state == S_EV_SHIFT) begin
              state <= S_FIT_SCAN;
            end else begin
              status    <= ST_HIT;
              out_valid <= 1'b1;
              state     <= S_IDLE;
            end
          end else if (!rd_live) begin
            rd_live <= 1'b1;
          end else begin
            pos     <= pos + 1'b1;
            rd_live <= 1'b0;
          end
        end
        S_FIT_SCAN: begin
          if (!rd_live) begin
            if (count == '0) begin
              status    <= ST_MISS;
              out_valid <= 1'b1;
              state     <= S_IDLE;
            end else begin
              rd_live <= 1'b1;
            end
          end else begin
            if (fits) begin
              found       <= 1'b1;
              best        <= rd_idx;
              best_size   <= rdata.size;
              best_handle <= rdata.handle;
            end
            if (rd_idx + 1'b1 >= count) begin
              rd_live <= 1'b0;
              if (fits || found) begin
                handle_out <= fits ? rdata.handle : best_handle;
                size_out   <= fits ? rdata.size : best_size;
                pos        <= fits ? rd_idx : best;
                state      <= S_FIT_SHIFT;
              end else begin
                status    <= ST_MISS;
                out_valid <= 1'b1;
                state     <= S_IDLE;
              end
            end else begin
              rd_idx <= rd_idx + 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The pool never holds more entries than its depth.
  assert property (@(posedge clk) disable iff (rst) count <= FullCnt)
    else $error("pool count beyond depth");
  // A release on a full pool is always dropped.
  assert property (@(posedge clk) disable iff (rst)
    accept && req_type && count == FullCnt |=> status == ST_DROPPED)
    else $error("full pool did not drop release");
  // A release never reports an eviction.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_STORED || status == ST_DROPPED) |-> !evicted)
    else $error("release reported eviction");
  // Shifts never write past the filled part of the pool.
  assert property (@(posedge clk) disable iff (rst)
    we && state != S_IDLE |-> pos + 1'b1 < count)
    else $error("shift write beyond count");

endmodule

// File: tb/sv/deferred_best_fit_buffer_pool_tb.sv
module deferred_best_fit_buffer_pool_tb;
  import dbfbp_pkg::*;

  localparam int PoolDepth = 16;
  localparam longint CycleLimit = 1000000;
  localparam int RandomPerPhase = 300;

  typedef struct {
    logic               rtype;
    logic [FrameW-1:0]  frame;
    logic [SizeW-1:0]   size;
    logic [KindW-1:0]   kind;
    logic [UsageW-1:0]  usage;
    logic               map;
    logic [HandleW-1:0] handle;
  } request_t;

  typedef struct {
    logic [1:0]         status;
    logic [HandleW-1:0] handle;
    logic [SizeW-1:0]   size;
    logic               ev;
    logic [HandleW-1:0] ev_handle;
    logic               ev_mapped;
  } outcome_t;

  typedef enum logic { ROW_REQ, ROW_CFG } row_kind_e;

  typedef struct {
    row_kind_e       kind;
    logic            cfg_idx;
    logic [CfgW-1:0] cfg_val;
    request_t        req;
    bit              typed;
    outcome_t        outcome;
  } stim_row_t;

  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_we;
  logic               cfg_index;
  logic [CfgW-1:0]    cfg_data;
  logic               in_valid;
  logic               in_stall;
  logic               req_type;
  logic [FrameW-1:0]  frame_now;
  logic [SizeW-1:0]   req_size;
  logic [KindW-1:0]   mem_kind;
  logic [UsageW-1:0]  usage_bits;
  logic               mapping;
  logic [HandleW-1:0] handle_in;
  logic               out_valid;
  logic               out_stall;
  logic [1:0]         status;
  logic [HandleW-1:0] handle_out;
  logic [SizeW-1:0]   size_out;
  logic               evicted;
  logic [HandleW-1:0] evicted_handle;
  logic               evicted_mapped;

  deferred_best_fit_buffer_pool #(.POOL_DEPTH(PoolDepth)) u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .req_type(req_type), .frame_now(frame_now),
    .req_size(req_size), .mem_kind(mem_kind), .usage_bits(usage_bits), .mapping(mapping),
    .handle_in(handle_in), .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .handle_out(handle_out), .size_out(size_out), .evicted(evicted),
    .evicted_handle(evicted_handle), .evicted_mapped(evicted_mapped)
  );

  always #2 clk = ~clk;

  // Shadow copy of the pool and its registers.
  entry_t                 pool[$];
  logic [BudgetW-1:0]     budget_shadow;
  logic [DelayW-1:0]      delay_shadow;
  outcome_t               pending_outcomes[$];
  stim_row_t              rows[$];
  int                     gap_pct;
  int                     stall_pct;
  int                     mismatch_count;
  longint                 cycle_count;
  logic [FrameW-1:0]      frame_cursor;

  // An entry may be reused once its release frame plus the delay lies behind now.
  function automatic bit is_ripe(entry_t e, logic [FrameW-1:0] now);
    logic [FrameW:0] due;
    due = {1'b0, e.frame} + {{(FrameW+1-DelayW){1'b0}}, delay_shadow};
    return due < {1'b0, now};
  endfunction

  // Applies one request to the shadow pool and returns the outcome it produces.
  function automatic outcome_t serve_request(request_t r);
    outcome_t o;
    entry_t e;
    longint unsigned running;
    int best;
    o = '{default: '0};
    if (r.rtype == REQ_RELEASE) begin
      if (pool.size() >= PoolDepth) begin
        o.status = ST_DROPPED;
      end else begin
        e.frame = r.frame;
        e.size = r.size;
        e.kind = r.kind;
        e.usage = r.usage;
        e.mapped = r.map;
        e.handle = r.handle;
        pool = {pool, e};
        o.status = ST_STORED;
      end
      return o;
    end
    // Evict the first ripe entry at which the running size passes the budget.
    running = 0;
    for (int i = 0; i < pool.size(); i++) begin
      running += pool[i].size;
      if (running > budget_shadow && is_ripe(pool[i], r.frame)) begin
        o.ev = 1'b1;
        o.ev_handle = pool[i].handle;
        o.ev_mapped = pool[i].mapped;
        pool.delete(i);
        break;
      end
    end
    // Smallest ripe exact match; strict compare keeps the earliest on a tie.
    best = -1;
    for (int i = 0; i < pool.size(); i++) begin
      if (is_ripe(pool[i], r.frame) && pool[i].kind == r.kind && pool[i].usage == r.usage &&
          pool[i].size >= r.size && !(r.map && !pool[i].mapped)) begin
        if (best < 0 || pool[i].size < pool[best].size) best = i;
      end
    end
    if (best >= 0) begin
      o.status = ST_HIT;
      o.handle = pool[best].handle;
      o.size = pool[best].size;
      pool.delete(best);
    end else begin
      o.status = ST_MISS;
    end
    return o;
  endfunction

  function automatic request_t make_req(logic rtype, logic [FrameW-1:0] frame,
                                        logic [SizeW-1:0] size, logic [KindW-1:0] kind,
                                        logic [UsageW-1:0] usage, logic map,
                                        logic [HandleW-1:0] handle);
    request_t r;
    r.rtype = rtype;
    r.frame = frame;
    r.size = size;
    r.kind = kind;
    r.usage = usage;
    r.map = map;
    r.handle = handle;
    return r;
  endfunction

  task automatic add_req(request_t r);
    stim_row_t row;
    row = '{kind: ROW_REQ, default: '0};
    row.req = r;
    rows = {rows, row};
  endtask

  task automatic add_typed(request_t r, outcome_t o);
    stim_row_t row;
    row = '{kind: ROW_REQ, default: '0};
    row.req = r;
    row.typed = 1'b1;
    row.outcome = o;
    rows = {rows, row};
  endtask

  task automatic add_cfg(logic idx, logic [CfgW-1:0] val);
    stim_row_t row;
    row = '{kind: ROW_CFG, default: '0};
    row.cfg_idx = idx;
    row.cfg_val = val;
    rows = {rows, row};
  endtask

  // Mostly well-formed traffic over a few kinds and flag sets, plus some wide noise.
  function automatic request_t random_req();
    request_t r;
    logic [UsageW-1:0] flag_sets[4];
    flag_sets = '{32'h0000_0001, 32'h0000_0021, 32'h8000_0400, 32'hffff_ffff};
    if ($urandom_range(99) < 3) frame_cursor = $urandom();
    else frame_cursor = frame_cursor + $urandom_range(3);
    r.frame = frame_cursor;
    r.rtype = ($urandom_range(99) < 55) ? REQ_RELEASE : REQ_GET;
    r.kind = ($urandom_range(99) < 90) ? KindW'($urandom_range(2)) : KindW'($urandom());
    r.usage = ($urandom_range(99) < 90) ? flag_sets[$urandom_range(3)] : $urandom();
    r.size = ($urandom_range(99) < 90) ? SizeW'($urandom_range(2000))
                                       : SizeW'({$urandom(), $urandom()});
    if (r.rtype == REQ_GET && $urandom_range(99) < 40) r.size = '0;
    r.map = 1'($urandom_range(1));
    r.handle = $urandom();
    return r;
  endfunction

  // Waits until every pending result has come back, then writes a register.
  task automatic write_reg(logic idx, logic [CfgW-1:0] val);
    in_valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_BUDGET) budget_shadow = val[BudgetW-1:0];
    else delay_shadow = val[DelayW-1:0];
  endtask

  // Presents one word and records its expected result once it is taken.
  task automatic send_req(request_t r, bit typed, outcome_t typed_outcome);
    outcome_t o;
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= r.rtype;
    frame_now <= r.frame;
    req_size <= r.size;
    mem_kind <= r.kind;
    usage_bits <= r.usage;
    mapping <= r.map;
    handle_in <= r.handle;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    o = serve_request(r);
    if (typed) o = typed_outcome;
    pending_outcomes = {pending_outcomes, o};
  endtask

  // Receiver stalls.
  always @(posedge clk) begin
    out_stall <= rst ? 1'b0 : ($urandom_range(99) < stall_pct);
  end

  // Result checker.
  always @(posedge clk) begin
    outcome_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_outcomes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("Unexpected result word, status %0d", status);
      end else begin
        want = pending_outcomes.pop_front();
        if (status !== want.status || handle_out !== want.handle || size_out !== want.size ||
            evicted !== want.ev || evicted_handle !== want.ev_handle ||
            evicted_mapped !== want.ev_mapped) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("Mismatch: expected st=%0d h=%h sz=%h ev=%b evh=%h evm=%b", want.status,
                     want.handle, want.size, want.ev, want.ev_handle, want.ev_mapped);
            $display("          actual   st=%0d h=%h sz=%h ev=%b evh=%h evm=%b", status,
                     handle_out, size_out, evicted, evicted_handle, evicted_mapped);
          end
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    outcome_t none;
    outcome_t o;
    int phase_gap[4];
    int phase_stall[4];
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_BUDGET;
    cfg_data = '0;
    in_valid = 1'b0;
    req_type = REQ_GET;
    frame_now = '0;
    req_size = '0;
    mem_kind = '0;
    usage_bits = '0;
    mapping = 1'b0;
    handle_in = '0;
    out_stall = 1'b0;
    gap_pct = 0;
    stall_pct = 0;
    mismatch_count = 0;
    cycle_count = 0;
    frame_cursor = '0;
    budget_shadow = '1;
    delay_shadow = 8'd2;
    none = '{default: '0};
    phase_gap = '{0, 51, 0, 6};
    phase_stall = '{0, 0, 51, 6};

    // Directed table: empty pool, extremes, full pool, eviction and ties.
    o = none;
    o.status = ST_MISS;
    add_typed(make_req(REQ_GET, '0, '0, '0, '0, 1'b0, '0), o);
    o = none;
    o.status = ST_STORED;
    add_typed(make_req(REQ_RELEASE, '0, '1, '1, '1, 1'b1, '1), o);
    o = none;
    o.status = ST_MISS;
    add_typed(make_req(REQ_GET, 32'd2, '1, '1, '1, 1'b1, '0), o);
    o = none;
    o.status = ST_HIT;
    o.handle = '1;
    o.size = '1;
    add_typed(make_req(REQ_GET, 32'd3, '1, '1, '1, 1'b1, '0), o);
    for (int i = 0; i < PoolDepth; i++) begin
      add_req(make_req(REQ_RELEASE, 32'd10, SizeW'((i % 8) * 100 + 100), 4'd1, 32'd5,
                       i[0], HandleW'(i + 1)));
    end
    o = none;
    o.status = ST_DROPPED;
    add_typed(make_req(REQ_RELEASE, 32'd11, 40'd7, 4'd1, 32'd5, 1'b1, 32'hdead), o);
    add_cfg(CFG_BUDGET, '0);
    add_req(make_req(REQ_GET, 32'd100, '0, 4'd2, 32'd5, 1'b0, '0));
    add_req(make_req(REQ_GET, 32'd100, '0, 4'd1, 32'd5, 1'b1, '0));
    add_cfg(CFG_BUDGET, {CfgW{1'b1}});
    add_cfg(CFG_DELAY, CfgW'(255));
    add_req(make_req(REQ_GET, '1, 40'd150, 4'd1, 32'd5, 1'b0, '0));
    add_req(make_req(REQ_GET, '1, '0, 4'd1, 32'd5, 1'b0, '0));

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) write_reg(rows[i].cfg_idx, rows[i].cfg_val);
      else send_req(rows[i].req, rows[i].typed, rows[i].outcome);
    end

    // Random phases under different idling and register settings.
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          write_reg(CFG_BUDGET, CfgW'(3000));
          write_reg(CFG_DELAY, CfgW'(2));
        end
        1: begin
          write_reg(CFG_BUDGET, '0);
          write_reg(CFG_DELAY, '0);
        end
        2: begin
          write_reg(CFG_BUDGET, CfgW'($urandom_range(5000, 500)));
          write_reg(CFG_DELAY, CfgW'(1));
        end
        default: begin
          write_reg(CFG_BUDGET, {CfgW{1'b1}});
          write_reg(CFG_DELAY, CfgW'(255));
        end
      endcase
      gap_pct = phase_gap[p];
      stall_pct = phase_stall[p];
      for (int n = 0; n < RandomPerPhase; n++) send_req(random_req(), 1'b0, none);
    end
    in_valid <= 1'b0;

    // Drain and settle.
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
